### rtl/ltps_pkg.sv
// Shared widths, codes and reset values for the link-test statistics block.
package ltps_pkg;

	localparam int FUNC_W  = 2;
	localparam int WORD_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int MS_W    = 16;
	localparam int PHASE_W = 3;
	localparam int CFG_IDX_W = 1;

	// item functions
	localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PACKET = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

	// session phases
	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_LISTEN  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_TIMEOUT = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SILENCE = 3'd3;
	localparam logic [PHASE_W-1:0] PH_MARKER  = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_LIMIT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT = 1'd1;

	localparam logic [MS_W-1:0]   LISTEN_LIMIT_RST  = 16'd15000;
	localparam logic [MS_W-1:0]   SILENCE_LIMIT_RST = 16'd3000;
	localparam logic [WORD_W-1:0] END_MARKER        = 32'hDEAD_BEEF;
	localparam logic [WORD_W-1:0] SEQ_SENTINEL      = 32'hFFFF_FFFF;
	localparam logic signed [BYTE_W-1:0] RSSI_MAX_RST = -8'sd128;
	localparam logic signed [BYTE_W-1:0] RSSI_LOW_RST = 8'sd0;

endpackage

### rtl/ltps_intf.sv
// Handshake channel interfaces: input items, result items and register writes.
interface ltps_in_if import ltps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [WORD_W-1:0] seq_word;
	logic [WORD_W-1:0] tail_word;
	logic [BYTE_W-1:0] rssi_byte;

	modport source (output valid, func, seq_word, tail_word, rssi_byte, input ready);
	modport sink   (input valid, func, seq_word, tail_word, rssi_byte, output ready);
endinterface

interface ltps_out_if import ltps_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [PHASE_W-1:0]        session_status;
	logic [WORD_W-1:0]         received_total;
	logic [WORD_W-1:0]         unique_total;
	logic [WORD_W-1:0]         duplicate_total;
	logic [WORD_W-1:0]         highest_seq;
	logic [WORD_W-1:0]         expected_total;
	logic [WORD_W-1:0]         lost_total;
	logic [MS_W-1:0]           elapsed_ticks;
	logic signed [WORD_W-1:0]  rssi_total;
	logic [MS_W-1:0]           rssi_samples;
	logic signed [BYTE_W-1:0]  rssi_lowest;
	logic signed [BYTE_W-1:0]  rssi_highest;

	modport source (output valid, session_status, received_total, unique_total,
		duplicate_total, highest_seq, expected_total, lost_total, elapsed_ticks,
		rssi_total, rssi_samples, rssi_lowest, rssi_highest, input ready);
	modport sink (input valid, session_status, received_total, unique_total,
		duplicate_total, highest_seq, expected_total, lost_total, elapsed_ticks,
		rssi_total, rssi_samples, rssi_lowest, rssi_highest, output ready);
endinterface

interface ltps_cfg_if import ltps_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [MS_W-1:0]      wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### rtl/link_test_packet_statistics.sv
// Link-test receive statistics: session control, packet counters and RSSI tracking.
//
// One result item per input item, one item accepted every cycle unless a stalled
// result has backed up the pipeline. An item passes an input register, then the
// statistics registers are updated from it (counter increments, sequence and RSSI
// compares, limit checks), then the expected and lost totals are formed into the
// result register. A stalled result holds the pipeline back stage by stage, so the
// input is only refused once all three stages are occupied. Limit registers are
// written through the cfg channel, which is always ready; write them only while no
// item is in flight.
module link_test_packet_statistics import ltps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ltps_in_if.sink    in_ch,
	ltps_out_if.source out_ch,
	ltps_cfg_if.sink   cfg
);

	function automatic logic [MS_W-1:0] sat_inc(input logic [MS_W-1:0] v);
		return (v == {MS_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	// limit registers
	logic [MS_W-1:0] listen_limit_q, silence_limit_q;

	// input register
	logic              valid_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [WORD_W-1:0] seq_s1, tail_s1;
	logic [BYTE_W-1:0] rbyte_s1;

	// statistics state; valid_s2 marks a state update whose result is owed
	logic                     valid_s2;
	logic [PHASE_W-1:0]       phase_q, phase_n;
	logic [WORD_W-1:0]        received_q, received_n;
	logic [WORD_W-1:0]        unique_q, unique_n;
	logic [WORD_W-1:0]        duplicate_q, duplicate_n;
	logic [WORD_W-1:0]        prev_seq_q, prev_seq_n;
	logic                     prev_valid_q, prev_valid_n;
	logic [WORD_W-1:0]        max_seq_q, max_seq_n;
	logic [WORD_W-1:0]        sender_q, sender_n;
	logic [MS_W-1:0]          elapsed_q, elapsed_n;
	logic [MS_W-1:0]          silence_q, silence_n;
	logic [WORD_W-1:0]        rssi_sum_q, rssi_sum_n;
	logic [MS_W-1:0]          rssi_cnt_q, rssi_cnt_n;
	logic signed [BYTE_W-1:0] rssi_low_q, rssi_low_n;
	logic signed [BYTE_W-1:0] rssi_max_q, rssi_max_n;

	logic signed [BYTE_W-1:0] rssi;
	logic [WORD_W-1:0]        expected;

	// result register
	logic out_valid_q;

	logic out_free, s2_free, upd, in_acc;

	assign out_free = !out_valid_q || out_ch.ready;
	assign s2_free  = !valid_s2 || out_free;
	assign upd      = valid_s1 && s2_free;
	assign in_acc   = in_ch.valid && in_ch.ready;

	assign in_ch.ready  = !valid_s1 || s2_free;
	assign cfg.ready    = 1'b1;
	assign out_ch.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_limit_q  <= LISTEN_LIMIT_RST;
			silence_limit_q <= SILENCE_LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				CFG_LISTEN_LIMIT:  listen_limit_q  <= cfg.wdata;
				CFG_SILENCE_LIMIT: silence_limit_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1  <= in_ch.func;
			seq_s1   <= in_ch.seq_word;
			tail_s1  <= in_ch.tail_word;
			rbyte_s1 <= in_ch.rssi_byte;
		end
	end

	// RSSI is the negated status byte, wrapped to eight bits
	assign rssi = signed'(BYTE_W'(-rbyte_s1));

	always_comb begin
		phase_n      = phase_q;
		received_n   = received_q;
		unique_n     = unique_q;
		duplicate_n  = duplicate_q;
		prev_seq_n   = prev_seq_q;
		prev_valid_n = prev_valid_q;
		max_seq_n    = max_seq_q;
		sender_n     = sender_q;
		elapsed_n    = elapsed_q;
		silence_n    = silence_q;
		rssi_sum_n   = rssi_sum_q;
		rssi_cnt_n   = rssi_cnt_q;
		rssi_low_n   = rssi_low_q;
		rssi_max_n   = rssi_max_q;
		case (func_s1)
			FUNC_START: begin
				phase_n      = PH_LISTEN;
				received_n   = '0;
				unique_n     = '0;
				duplicate_n  = '0;
				prev_seq_n   = SEQ_SENTINEL;
				prev_valid_n = 1'b0;
				max_seq_n    = '0;
				sender_n     = '0;
				elapsed_n    = '0;
				silence_n    = '0;
				rssi_sum_n   = '0;
				rssi_cnt_n   = '0;
				rssi_low_n   = RSSI_LOW_RST;
				rssi_max_n   = RSSI_MAX_RST;
			end
			FUNC_PACKET: begin
				if (phase_q == PH_LISTEN) begin
					rssi_sum_n = rssi_sum_q + WORD_W'(rssi);
					rssi_cnt_n = rssi_cnt_q + 1'b1;
					if (rssi < rssi_low_q)
						rssi_low_n = rssi;
					if (rssi > rssi_max_q)
						rssi_max_n = rssi;
					if (seq_s1 == END_MARKER) begin
						sender_n = tail_s1;
						phase_n  = PH_MARKER;
					end else begin
						received_n = received_q + 1'b1;
						if (prev_valid_q && seq_s1 == prev_seq_q)
							duplicate_n = duplicate_q + 1'b1;
						else
							unique_n = unique_q + 1'b1;
						prev_seq_n   = seq_s1;
						prev_valid_n = 1'b1;
						if (seq_s1 > max_seq_q)
							max_seq_n = seq_s1;
						silence_n = '0;
					end
				end
			end
			FUNC_TICK: begin
				if (phase_q == PH_LISTEN) begin
					elapsed_n = sat_inc(elapsed_q);
					silence_n = sat_inc(silence_q);
					// listen limit takes precedence over silence
					if (elapsed_n >= listen_limit_q)
						phase_n = PH_TIMEOUT;
					else if (received_q != '0 && silence_n >= silence_limit_q)
						phase_n = PH_SILENCE;
				end
			end
			default: ;
		endcase
	end

	// stage 2: statistics state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			phase_q      <= PH_IDLE;
			received_q   <= '0;
			unique_q     <= '0;
			duplicate_q  <= '0;
			prev_seq_q   <= SEQ_SENTINEL;
			prev_valid_q <= 1'b0;
			max_seq_q    <= '0;
			sender_q     <= '0;
			elapsed_q    <= '0;
			silence_q    <= '0;
			rssi_sum_q   <= '0;
			rssi_cnt_q   <= '0;
			rssi_low_q   <= RSSI_LOW_RST;
			rssi_max_q   <= RSSI_MAX_RST;
		end else begin
			if (s2_free)
				valid_s2 <= valid_s1;
			if (upd) begin
				phase_q      <= phase_n;
				received_q   <= received_n;
				unique_q     <= unique_n;
				duplicate_q  <= duplicate_n;
				prev_seq_q   <= prev_seq_n;
				prev_valid_q <= prev_valid_n;
				max_seq_q    <= max_seq_n;
				sender_q     <= sender_n;
				elapsed_q    <= elapsed_n;
				silence_q    <= silence_n;
				rssi_sum_q   <= rssi_sum_n;
				rssi_cnt_q   <= rssi_cnt_n;
				rssi_low_q   <= rssi_low_n;
				rssi_max_q   <= rssi_max_n;
			end
		end
	end

	// a latched sender total of zero counts as none
	assign expected = (sender_q != '0) ? sender_q : max_seq_q + 1'b1;

	// stage 3: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && out_free) begin
			out_ch.session_status  <= phase_q;
			out_ch.received_total  <= received_q;
			out_ch.unique_total    <= unique_q;
			out_ch.duplicate_total <= duplicate_q;
			out_ch.highest_seq     <= max_seq_q;
			out_ch.expected_total  <= expected;
			out_ch.lost_total      <= (expected > received_q) ? expected - received_q : '0;
			out_ch.elapsed_ticks   <= elapsed_q;
			out_ch.rssi_total      <= signed'(rssi_sum_q);
			out_ch.rssi_samples    <= rssi_cnt_q;
			out_ch.rssi_lowest     <= rssi_low_q;
			out_ch.rssi_highest    <= rssi_max_q;
		end
	end

	// every data packet is either unique or a duplicate
	a_count_split: assert property (@(posedge clk) disable iff (!arst_n)
		received_q == unique_q + duplicate_q)
		else $error("received count differs from unique plus duplicate");

	// once a session has been opened the block never returns to idle
	a_no_idle_return: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE |=> phase_q != PH_IDLE)
		else $error("phase returned to idle");

	// outside listening only a start item moves the phase
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		upd && func_s1 != FUNC_START && phase_q != PH_LISTEN |=> $stable(phase_q))
		else $error("phase changed outside a session");

	// an accepted item always lands in the input register
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted item lost at input register");

endmodule

### test/link_test_packet_statistics_checker.sv
// Checker for the link-test statistics block: predicts every item's result and compares it.
module link_test_packet_statistics_checker import ltps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ltps_in_if   in_ch,
	ltps_out_if  out_ch,
	ltps_cfg_if  cfg,
	output int   fails,
	output int   outstanding
);

	typedef struct packed {
		logic [PHASE_W-1:0]       status;
		logic [WORD_W-1:0]        rx_total;
		logic [WORD_W-1:0]        uniq_total;
		logic [WORD_W-1:0]        dup_total;
		logic [WORD_W-1:0]        top_seq;
		logic [WORD_W-1:0]        exp_total;
		logic [WORD_W-1:0]        lost_total;
		logic [MS_W-1:0]          elapsed;
		logic signed [WORD_W-1:0] rssi_sum;
		logic [MS_W-1:0]          rssi_n;
		logic signed [BYTE_W-1:0] rssi_lo;
		logic signed [BYTE_W-1:0] rssi_hi;
	} stats_t;

	// limits as last written
	logic [MS_W-1:0] listen_lim;
	logic [MS_W-1:0] silence_lim;

	// session state
	logic [PHASE_W-1:0]       sess_phase;
	logic [WORD_W-1:0]        rx_n;
	logic [WORD_W-1:0]        uniq_n;
	logic [WORD_W-1:0]        dup_n;
	logic [WORD_W-1:0]        prev_seq;
	logic                     prev_ok;
	logic [WORD_W-1:0]        max_seq;
	logic [WORD_W-1:0]        sender_n;
	logic [MS_W-1:0]          elapsed_n;
	logic [MS_W-1:0]          quiet_ms;
	logic [WORD_W-1:0]        rssi_acc;
	logic [MS_W-1:0]          rssi_cnt;
	logic signed [BYTE_W-1:0] rssi_low;
	logic signed [BYTE_W-1:0] rssi_max;

	stats_t predicted_stats[$];
	stats_t want;
	stats_t got;
	int     result_no;

	function automatic void clear_session();
		rx_n      = '0;
		uniq_n    = '0;
		dup_n     = '0;
		prev_seq  = SEQ_SENTINEL;
		prev_ok   = 1'b0;
		max_seq   = '0;
		sender_n  = '0;
		elapsed_n = '0;
		quiet_ms  = '0;
		rssi_acc  = '0;
		rssi_cnt  = '0;
		rssi_low  = RSSI_LOW_RST;
		rssi_max  = RSSI_MAX_RST;
	endfunction

	function automatic stats_t advance_session(input logic [FUNC_W-1:0] f,
			input logic [WORD_W-1:0] seq, input logic [WORD_W-1:0] tail,
			input logic [BYTE_W-1:0] rbyte);
		logic signed [BYTE_W-1:0] rssi;
		logic [WORD_W-1:0]        exp_n;
		stats_t                   s;
		if (f == FUNC_START) begin
			clear_session();
			sess_phase = PH_LISTEN;
		end else if (f == FUNC_PACKET && sess_phase == PH_LISTEN) begin
			// magnitude byte negated, wrapping at 8 bits
			rssi = 8'd0 - rbyte;
			rssi_acc = rssi_acc + {{(WORD_W-BYTE_W){rssi[BYTE_W-1]}}, rssi};
			rssi_cnt = rssi_cnt + 1'b1;
			if (rssi < rssi_low)
				rssi_low = rssi;
			if (rssi > rssi_max)
				rssi_max = rssi;
			if (seq == END_MARKER) begin
				sender_n = tail;
				sess_phase = PH_MARKER;
			end else begin
				rx_n = rx_n + 1'b1;
				if (prev_ok && seq == prev_seq)
					dup_n = dup_n + 1'b1;
				else
					uniq_n = uniq_n + 1'b1;
				prev_seq = seq;
				prev_ok = 1'b1;
				if (seq > max_seq)
					max_seq = seq;
				quiet_ms = '0;
			end
		end else if (f == FUNC_TICK && sess_phase == PH_LISTEN) begin
			if (elapsed_n != '1)
				elapsed_n = elapsed_n + 1'b1;
			if (quiet_ms != '1)
				quiet_ms = quiet_ms + 1'b1;
			// listen limit takes precedence
			if (elapsed_n >= listen_lim)
				sess_phase = PH_TIMEOUT;
			else if (rx_n != '0 && quiet_ms >= silence_lim)
				sess_phase = PH_SILENCE;
		end
		exp_n = (sender_n != '0) ? sender_n : max_seq + 1'b1;
		s.status     = sess_phase;
		s.rx_total   = rx_n;
		s.uniq_total = uniq_n;
		s.dup_total  = dup_n;
		s.top_seq    = max_seq;
		s.exp_total  = exp_n;
		s.lost_total = (exp_n > rx_n) ? exp_n - rx_n : '0;
		s.elapsed    = elapsed_n;
		s.rssi_sum   = rssi_acc;
		s.rssi_n     = rssi_cnt;
		s.rssi_lo    = rssi_low;
		s.rssi_hi    = rssi_max;
		return s;
	endfunction

	function automatic string stats_text(input stats_t s);
		return $sformatf({"st=%0d rx=%0d uniq=%0d dup=%0d top=%h exp=%h lost=%0d",
			" ms=%0d sum=%0d n=%0d lo=%0d hi=%0d"},
			s.status, s.rx_total, s.uniq_total, s.dup_total, s.top_seq, s.exp_total,
			s.lost_total, s.elapsed, s.rssi_sum, s.rssi_n, s.rssi_lo, s.rssi_hi);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_lim = LISTEN_LIMIT_RST;
			silence_lim = SILENCE_LIMIT_RST;
			sess_phase = PH_IDLE;
			clear_session();
			predicted_stats.delete();
			result_no = 0;
			fails <= 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					CFG_LISTEN_LIMIT:  listen_lim = cfg.wdata;
					CFG_SILENCE_LIMIT: silence_lim = cfg.wdata;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				predicted_stats.push_back(advance_session(in_ch.func, in_ch.seq_word,
					in_ch.tail_word, in_ch.rssi_byte));
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.session_status, out_ch.received_total, out_ch.unique_total,
					out_ch.duplicate_total, out_ch.highest_seq, out_ch.expected_total,
					out_ch.lost_total, out_ch.elapsed_ticks, out_ch.rssi_total,
					out_ch.rssi_samples, out_ch.rssi_lowest, out_ch.rssi_highest};
				if (predicted_stats.size() == 0) begin
					if (fails < 10)
						$display("result %0d with no item pending: %s", result_no,
							stats_text(got));
					fails <= fails + 1;
				end else begin
					want = predicted_stats.pop_front();
					if (got !== want) begin
						if (fails < 10) begin
							$display("result %0d expected %s", result_no, stats_text(want));
							$display("result %0d actual   %s", result_no, stats_text(got));
						end
						fails <= fails + 1;
					end
				end
				result_no = result_no + 1;
			end
			outstanding <= predicted_stats.size();
		end
	end

endmodule

### test/link_test_packet_statistics_test.sv
// Testbench top for the link-test statistics block: clock, reset, stimulus and verdict.
module link_test_packet_statistics_test import ltps_pkg::*; ();

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;

	int fails;
	int outstanding;
	int idle_cycles = 0;
	int stall_left = 0;
	int calm_left = 0;
	bit quiet = 1'b0;
	int cur_silence = int'(SILENCE_LIMIT_RST);

	ltps_in_if  in_ch();
	ltps_out_if out_ch();
	ltps_cfg_if cfg();

	assign out_ch.ready = sink_ready;

	link_test_packet_statistics dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	link_test_packet_statistics_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg         (cfg),
		.fails       (fails),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else if (stall_left > 0) begin
			sink_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			sink_ready <= 1'b1;
			if (calm_left > 0)
				calm_left = calm_left - 1;
			else if ($urandom_range(0, 199) == 0)
				calm_left = $urandom_range(20, 100);
			else
				stall_left = idle_gap();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("[link_test_packet_statistics] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// called at a rising edge; returns at the edge where the item was taken
	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] seq,
			input logic [WORD_W-1:0] tail, input logic [BYTE_W-1:0] rbyte);
		int gap;
		gap = quiet ? 0 : idle_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.func      <= f;
		in_ch.seq_word  <= seq;
		in_ch.tail_word <= tail;
		in_ch.rssi_byte <= rbyte;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// limits only change once every result has come back
	task automatic write_limits(input logic [MS_W-1:0] listen, input logic [MS_W-1:0] silence);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
		cfg.valid     <= 1'b1;
		cfg.reg_index <= CFG_LISTEN_LIMIT;
		cfg.wdata     <= listen;
		do @(posedge clk); while (!cfg.ready);
		cfg.reg_index <= CFG_SILENCE_LIMIT;
		cfg.wdata     <= silence;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		cur_silence = int'(silence);
	endtask

	task automatic run_sessions(input int budget);
		int sent;
		int len;
		int k;
		int j;
		int burst;
		int roll;
		logic [WORD_W-1:0] seq;
		logic [WORD_W-1:0] tail;
		sent = 0;
		while (sent < budget) begin
			quiet = ($urandom_range(0, 4) == 0);
			// stray item between sessions
			if ($urandom_range(0, 3) == 0) begin
				send_item(FUNC_W'($urandom_range(FUNC_PACKET, FUNC_UNUSED)), $urandom,
					$urandom, BYTE_W'($urandom_range(0, 255)));
				sent = sent + 1;
			end
			send_item(FUNC_START, $urandom, $urandom, BYTE_W'($urandom_range(0, 255)));
			sent = sent + 1;
			seq = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 3);
			len = $urandom_range(4, 40);
			for (k = 0; k < len && sent < budget; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					roll = $urandom_range(0, 99);
					if (roll < 60)
						seq = seq + 1;
					else if (roll < 75)
						seq = seq;
					else if (roll < 85)
						seq = seq + $urandom_range(2, 6);
					else if (roll < 92)
						seq = seq - $urandom_range(1, 3);
					else if (roll < 97)
						seq = $urandom;
					else
						seq = SEQ_SENTINEL;
					if (seq == END_MARKER)
						seq = seq + 1;
					send_item(FUNC_PACKET, seq, $urandom, BYTE_W'($urandom_range(0, 255)));
					sent = sent + 1;
				end else if (roll < 88) begin
					// an occasional burst long enough to reach the silence limit, when that limit is under 80
					if ($urandom_range(0, 9) == 0)
						burst = (cur_silence < 80) ? cur_silence + 1 : 80;
					else
						burst = $urandom_range(1, 4);
					for (j = 0; j < burst; j++)
						send_item(FUNC_TICK, $urandom, $urandom,
							BYTE_W'($urandom_range(0, 255)));
					sent = sent + burst;
				end else if (roll < 94) begin
					send_item(FUNC_UNUSED, $urandom, $urandom, BYTE_W'($urandom_range(0, 255)));
					sent = sent + 1;
				end else begin
					send_item(FUNC_START, $urandom, $urandom, BYTE_W'($urandom_range(0, 255)));
					sent = sent + 1;
				end
			end
			if ($urandom_range(0, 9) < 6) begin
				roll = $urandom_range(0, 99);
				if (roll < 25)
					tail = '0;
				else if (roll < 60)
					tail = seq + $urandom_range(0, 8);
				else
					tail = $urandom;
				send_item(FUNC_PACKET, END_MARKER, tail, BYTE_W'($urandom_range(0, 255)));
				sent = sent + 1;
			end
		end
	endtask

	initial begin
		in_ch.valid     = 1'b0;
		in_ch.func      = FUNC_START;
		in_ch.seq_word  = '0;
		in_ch.tail_word = '0;
		in_ch.rssi_byte = '0;
		cfg.valid       = 1'b0;
		cfg.reg_index   = CFG_LISTEN_LIMIT;
		cfg.wdata       = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// outside a session: ignored
		send_item(FUNC_TICK, 32'd0, 32'd0, 8'h00);
		send_item(FUNC_PACKET, 32'd7, 32'd0, 8'h40);
		send_item(FUNC_UNUSED, SEQ_SENTINEL, SEQ_SENTINEL, 8'hFF);
		send_item(FUNC_START, 32'd0, 32'd0, 8'h00);
		// RSSI extremes, duplicates including the all-ones sequence
		send_item(FUNC_PACKET, 32'd0, 32'd0, 8'h00);
		send_item(FUNC_PACKET, 32'd0, 32'd0, 8'h80);
		send_item(FUNC_PACKET, SEQ_SENTINEL, 32'd0, 8'h7F);
		send_item(FUNC_PACKET, SEQ_SENTINEL, 32'd0, 8'h81);
		send_item(FUNC_TICK, 32'd0, 32'd0, 8'h00);
		send_item(FUNC_PACKET, 32'd5, 32'd0, 8'hFF);
		send_item(FUNC_PACKET, 32'd3, 32'd0, 8'h01);
		send_item(FUNC_UNUSED, 32'd3, 32'd0, 8'h01);
		send_item(FUNC_TICK, 32'd0, 32'd0, 8'h00);
		// marker with no total: expected falls back to highest + 1, wrapping
		send_item(FUNC_PACKET, END_MARKER, 32'd0, 8'h55);
		send_item(FUNC_TICK, 32'd0, 32'd0, 8'h00);
		send_item(FUNC_START, 32'd0, 32'd0, 8'h00);
		send_item(FUNC_PACKET, 32'd10, 32'd0, 8'h20);
		send_item(FUNC_START, 32'd0, 32'd0, 8'h00);
		send_item(FUNC_PACKET, 32'd2, 32'd0, 8'h30);
		send_item(FUNC_PACKET, END_MARKER, 32'd3, 8'hC0);

		// zero limits: both reached on one tick, timeout wins
		write_limits(16'd0, 16'd0);
		send_item(FUNC_START, 32'd0, 32'd0, 8'h00);
		send_item(FUNC_PACKET, 32'd1, 32'd0, 8'h10);
		send_item(FUNC_TICK, 32'd0, 32'd0, 8'h00);
		// silence only counts once a packet has arrived
		write_limits(16'hFFFF, 16'd0);
		send_item(FUNC_START, 32'd0, 32'd0, 8'h00);
		send_item(FUNC_TICK, 32'd0, 32'd0, 8'h00);
		send_item(FUNC_PACKET, 32'd0, 32'd0, 8'h10);
		send_item(FUNC_TICK, 32'd0, 32'd0, 8'h00);

		write_limits(16'd40, 16'd6);
		run_sessions(120);
		write_limits(16'hFFFF, 16'hFFFF);
		run_sessions(110);
		write_limits(16'd1, 16'd1);
		run_sessions(100);
		repeat (2) begin
			write_limits(MS_W'($urandom_range(20, 300)), MS_W'($urandom_range(2, 25)));
			run_sessions(110);
		end

		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		if (fails == 0 && outstanding == 0)
			$display("[link_test_packet_statistics] OK");
		else
			$display("[link_test_packet_statistics] ERROR");
		$finish;
	end

endmodule

### link_test_packet_statistics.f
rtl/ltps_pkg.sv
rtl/ltps_intf.sv
rtl/link_test_packet_statistics.sv
test/link_test_packet_statistics_checker.sv
test/link_test_packet_statistics_test.sv
